[rtl/trd_pkg.sv]
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the trap rearrangement destination block.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int MaxTrapsDef = 64;
  localparam int OccW        = 64;
  localparam int IdxW        = 6;
  localparam int DestW       = 7;
  localparam int CntW        = 7;
  localparam int ModeW       = 3;
  localparam int PaddrW      = 4;
  localparam int PdataW      = 32;

  // Destination code for an empty trap or a dropped atom (-1).
  localparam logic signed [DestW-1:0] DestDrop = '1;

  localparam logic [CntW-1:0] TrapCountRst = CntW'(64);

  typedef enum logic [ModeW-1:0] {
    MODE_STACK_LEFT  = 3'd0,
    MODE_STACK_RIGHT = 3'd1,
    MODE_FIXED_DROP  = 3'd2,
    MODE_FIXED_FAR   = 3'd3,
    MODE_FIXED_NEAR  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_TARGET = 2'd1,
    REG_GAP    = 2'd2,
    REG_COUNT  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_COUNT = 2'd1,
    S_EMIT  = 2'd2
  } state_t;

  typedef struct packed {
    logic [ModeW-1:0] arrange_mode;
    logic [CntW-1:0]  target_size;
    logic [CntW-1:0]  reservoir_gap;
    logic [CntW-1:0]  trap_count;
  } cfg_t;

endpackage

[rtl/trd_if.sv]
// ----------------------------------------------------------------------------
// trd_in_if / trd_out_if
// Valid/ready channels carrying occupancy words in and destination words out.
// ----------------------------------------------------------------------------
interface trd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] occupancy;

  modport source (output valid, output occupancy, input ready);
  modport sink   (input valid, input occupancy, output ready);
endinterface

interface trd_out_if;
  logic              valid;
  logic              ready;
  logic [5:0]        trap_pos;
  logic signed [6:0] destination;
  logic              last;

  modport source (output valid, output trap_pos, output destination, output last,
                  input ready);
  modport sink   (input valid, input trap_pos, input destination, input last,
                  output ready);
endinterface

[rtl/trd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// trd_cfg_regs
// APB-style register file: mode, target size, reservoir gap, trap count.
// ----------------------------------------------------------------------------
module trd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [trd_pkg::PaddrW-1:0]   paddr,
  input  logic [trd_pkg::PdataW-1:0]   pwdata,
  output logic [trd_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  output trd_pkg::cfg_t                cfg
);
  import trd_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PaddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arrange_mode  <= ModeW'(MODE_STACK_LEFT);
      cfg_r.target_size   <= '0;
      cfg_r.reservoir_gap <= '0;
      cfg_r.trap_count    <= TrapCountRst;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:   cfg_r.arrange_mode  <= pwdata[ModeW-1:0];
        REG_TARGET: cfg_r.target_size   <= pwdata[CntW-1:0];
        REG_GAP:    cfg_r.reservoir_gap <= pwdata[CntW-1:0];
        REG_COUNT:  cfg_r.trap_count    <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:   prdata = PdataW'(cfg_r.arrange_mode);
      REG_TARGET: prdata = PdataW'(cfg_r.target_size);
      REG_GAP:    prdata = PdataW'(cfg_r.reservoir_gap);
      REG_COUNT:  prdata = PdataW'(cfg_r.trap_count);
      default:    prdata = '0;
    endcase
  end

endmodule

[rtl/trap_rearrange_destinations_top.sv]
// ----------------------------------------------------------------------------
// trap_rearrange_destinations_top
// Per-shot destination generator for a row of traps.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    occupancy[63:0]
//   out_ch   out  valid/ready    trap_pos[5:0], destination[6:0] s, last
//   cfg      in   APB psel/pen   paddr[3:0], pwdata/prdata[31:0]
//
// A word passes the idle, count and emit states, N being the traps in use:
// idle takes it, count tallies atoms one trap a cycle through the shared
// accumulator, then emit gives one destination a cycle from the output
// register while that register is free. in_ch.ready is high only in idle; the
// next word may be taken while the final result still waits in the output register.
// Synchronous reset clears control state and loads register defaults
// (trap count 64).
// ----------------------------------------------------------------------------
module trap_rearrange_destinations_top #(
  parameter int MAX_TRAPS = trd_pkg::MaxTrapsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  trd_in_if.sink                       in_ch,
  trd_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [trd_pkg::PaddrW-1:0]   paddr,
  input  logic [trd_pkg::PdataW-1:0]   pwdata,
  output logic [trd_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);
  import trd_pkg::*;

  localparam logic [CntW-1:0] MaxN = CntW'(MAX_TRAPS);

  cfg_t   cfg;
  state_t state_r, state_nxt;

  logic [OccW-1:0]   held_r, held_nxt;
  logic [CntW-1:0]   total_r, total_nxt;
  logic [CntW-1:0]   walk_r, walk_nxt;
  logic [CntW-1:0]   seen_r, seen_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IdxW-1:0]   out_idx_r, out_idx_nxt;
  logic [DestW-1:0]  out_dest_r, out_dest_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CntW-1:0]   n_use;
  logic              bit_now;
  logic              walk_end;
  logic              out_free;
  logic [CntW-1:0]   acc_in;
  logic [CntW-1:0]   acc_sum;
  logic [DestW-1:0]  dest_now;

  trd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  function automatic logic [DestW-1:0] pick_dest(
    input logic             present,
    input logic [ModeW-1:0] mode,
    input logic [CntW-1:0]  target,
    input logic [CntW-1:0]  gap,
    input logic [CntW-1:0]  n,
    input logic [CntW-1:0]  left,
    input logic [CntW-1:0]  total
  );
    logic [CntW-1:0] right;
    logic [CntW-1:0] far;
    logic [CntW:0]   near;
    logic            keep;
    right = total - left;
    far   = n - right;
    near  = {1'b0, left} + {1'b0, gap};
    keep  = left < target;
    if (!present) begin
      pick_dest = DestDrop;
    end else begin
      case (mode_t'(mode))
        MODE_STACK_LEFT:  pick_dest = left;
        MODE_STACK_RIGHT: pick_dest = far;
        MODE_FIXED_DROP:  pick_dest = keep ? left : DestDrop;
        MODE_FIXED_FAR:   pick_dest = keep ? left : far;
        MODE_FIXED_NEAR: begin
          if (keep) pick_dest = left;
          else if (near < {1'b0, n}) pick_dest = near[CntW-1:0];
          else pick_dest = DestDrop;
        end
        default:          pick_dest = DestDrop;
      endcase
    end
  endfunction

  // Saturate trap count to 1..MAX_TRAPS.
  always_comb begin
    if (cfg.trap_count == '0) n_use = CntW'(1);
    else if (cfg.trap_count > MaxN) n_use = MaxN;
    else n_use = cfg.trap_count;
  end

  assign bit_now  = held_r[walk_r[IdxW-1:0]];
  assign walk_end = (walk_r + CntW'(1)) == n_use;
  assign out_free = !out_valid_r || out_ch.ready;

  // Shared accumulator: atom total while counting, atoms passed while emitting.
  assign acc_in  = (state_r == S_COUNT) ? total_r : seen_r;
  assign acc_sum = acc_in + CntW'(bit_now);

  assign dest_now = pick_dest(bit_now, cfg.arrange_mode, cfg.target_size,
                              cfg.reservoir_gap, n_use, seen_r, total_r);

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.trap_pos    = out_idx_r;
  assign out_ch.destination = out_dest_r;
  assign out_ch.last        = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    total_nxt     = total_r;
    walk_nxt      = walk_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_dest_nxt  = out_dest_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          held_nxt  = in_ch.occupancy;
          total_nxt = '0;
          walk_nxt  = '0;
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        total_nxt = acc_sum;
        if (walk_end) begin
          walk_nxt  = '0;
          seen_nxt  = '0;
          state_nxt = S_EMIT;
        end else begin
          walk_nxt = walk_r + CntW'(1);
        end
      end
      S_EMIT: begin
        // Advance only when the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = walk_r[IdxW-1:0];
          out_dest_nxt  = dest_now;
          out_last_nxt  = walk_end;
          seen_nxt      = acc_sum;
          if (walk_end) begin
            walk_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            walk_nxt = walk_r + CntW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      walk_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      walk_r      <= walk_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    out_idx_r  <= out_idx_nxt;
    out_dest_r <= out_dest_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTH
  a_accept_starts_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_COUNT)
    else $error("accepted word did not start the count phase");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready)
    else $error("input ready while busy");

  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COUNT |-> total_r <= walk_r)
    else $error("atom total exceeds traps visited");
`endif

endmodule
